// File: design/binary_heap_priority_queue_assert.svh
// Assertion macros for the binary heap priority queue.
// Both expect clk_i, and BHPQ_ASSERT also rst_ni, in the scope where they are used.
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset
`define BHPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bhpq: assertion failed");

// Checked at every edge, reset included
`define BHPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("bhpq: assertion failed");

`else

`define BHPQ_ASSERT(lbl, prop)
`define BHPQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: design/bhpq_pkg.sv
package bhpq_pkg;

  // Storage geometry: slot 0 is unused, slots 1..HEAP_SLOTS-1 hold entries
  localparam int HEAP_SLOTS   = 1024;
  localparam int ADDR_W       = $clog2(HEAP_SLOTS);
  localparam int CNT_W        = ADDR_W;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int ENTRY_W      = KEY_BITS + PAYLOAD_BITS;

  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(HEAP_SLOTS - 1);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic                    op;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [CNT_W-1:0]        occupancy;
  } out_item_t;

endpackage

// File: design/bhpq_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data
module bhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/binary_heap_priority_queue.sv
// Binary heap priority queue of key/payload entries held in one 1W1R RAM
// (slots 1..HEAP_SLOTS-1). order_mode 0 pops the largest key first, 1 the
// smallest; ties keep heap order, since entries move only when strictly better.
// One item is processed at a time and in_ready_o is low while a sift runs. A
// push moves up, comparing with each parent until it settles or reaches the
// root; a pop reads the root and, unless that empties the heap, the last
// entry, which it sifts down against the better child until it settles or
// reaches a leaf; a dropped push or an empty pop goes straight to the result.
// The pace is set by the single RAM read port: every level of a sift needs one
// (up) or two (down, one where only a left child exists) reads, each registered
// in the RAM ahead of the shared key comparator. The result waits in an output
// register, so the next item is taken while it is not yet consumed. The heap
// RAM needs no clearing after reset; only the control registers are reset.
`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue
  import bhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // configuration
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  // request channel
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  // result channel
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UP    = 4'd1;
  localparam logic [3:0] S_UPCMP = 4'd2;
  localparam logic [3:0] S_POP1  = 4'd3;
  localparam logic [3:0] S_POP2  = 4'd4;
  localparam logic [3:0] S_DN    = 4'd5;
  localparam logic [3:0] S_DNL   = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_DNC   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              mode_q, mode_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] pick_q, pick_d;
  entry_t            ent_q, ent_d;
  entry_t            child_q, child_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // RAM port signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;

  // Child indexes of the current slot
  logic [ADDR_W:0]   lc_idx;
  logic [ADDR_W:0]   rc_idx;
  logic [ADDR_W:0]   count_ext;

  // Shared key comparator
  logic [KEY_BITS-1:0] cmp_a;
  logic [KEY_BITS-1:0] cmp_b;
  logic                a_better;

  assign lc_idx    = {pos_q, 1'b0};
  assign rc_idx    = {pos_q, 1'b1};
  assign count_ext = {1'b0, count_q};

  bhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HEAP_SLOTS)
  ) u_heap_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Comparator operand select
  always_comb begin
    unique case (state_q)
      S_DNR: begin
        cmp_a = rd_data.key;
        cmp_b = child_q.key;
      end
      S_DNC: begin
        cmp_a = child_q.key;
        cmp_b = ent_q.key;
      end
      default: begin
        cmp_a = ent_q.key;
        cmp_b = rd_data.key;
      end
    endcase
  end

  assign a_better = mode_q ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  // Configuration register
  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    pick_d      = pick_q;
    ent_d       = ent_q;
    child_d     = child_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = ent_q;
    rd_en       = 1'b0;
    rd_addr     = pos_q;

    // result register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (in_item_i.op == OP_PUSH) begin
            if (count_q == CAPACITY) begin
              res_d.status = STATUS_FULL;
              state_d      = S_DONE;
            end else begin
              count_d     = count_q + CNT_W'(1);
              pos_d       = ADDR_W'(count_q + CNT_W'(1));
              ent_d       = '{key: in_item_i.key, payload: in_item_i.payload};
              res_d.status = STATUS_DONE;
              state_d     = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = STATUS_EMPTY;
              state_d      = S_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ADDR_W'(1);
              state_d = S_POP1;
            end
          end
        end
      end

      // sift-up: fetch parent, or settle at the root
      S_UP: begin
        if (pos_q == ADDR_W'(1)) begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_q >> 1;
          state_d = S_UPCMP;
        end
      end

      // parent moves down into the hole, or the entry settles here
      S_UPCMP: begin
        wr_en = 1'b1;
        if (a_better) begin
          wr_data = rd_data;
          pos_d   = pos_q >> 1;
          state_d = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end

      // root arrives; fetch the last entry unless the heap is now empty
      S_POP1: begin
        res_d.status      = STATUS_DONE;
        res_d.out_key     = rd_data.key;
        res_d.out_payload = rd_data.payload;
        count_d           = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(count_q);
          state_d = S_POP2;
        end
      end

      S_POP2: begin
        ent_d   = rd_data;
        pos_d   = ADDR_W'(1);
        state_d = S_DN;
      end

      // sift-down: fetch left child, or settle at a leaf
      S_DN: begin
        if (lc_idx > count_ext) begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = lc_idx[ADDR_W-1:0];
          state_d = S_DNL;
        end
      end

      // left child arrives; fetch right child if present
      S_DNL: begin
        child_d = rd_data;
        pick_d  = lc_idx[ADDR_W-1:0];
        if (rc_idx <= count_ext) begin
          rd_en   = 1'b1;
          rd_addr = rc_idx[ADDR_W-1:0];
          state_d = S_DNR;
        end else begin
          state_d = S_DNC;
        end
      end

      // right child wins only if strictly better
      S_DNR: begin
        if (a_better) begin
          child_d = rd_data;
          pick_d  = rc_idx[ADDR_W-1:0];
        end
        state_d = S_DNC;
      end

      // chosen child moves up into the hole, or the entry settles here
      S_DNC: begin
        wr_en = 1'b1;
        if (a_better) begin
          wr_data = child_q;
          pos_d   = pick_q;
          state_d = S_DN;
        end else begin
          state_d = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d           = res_q;
          out_d.occupancy = count_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    pick_q  <= pick_d;
    ent_q   <= ent_d;
    child_q <= child_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `BHPQ_ASSERT_ALWAYS(a_count_in_range, count_q <= CAPACITY)
  `BHPQ_ASSERT(a_write_in_heap, wr_en |-> (wr_addr != '0) && (wr_addr <= ADDR_W'(count_q)))
  `BHPQ_ASSERT(a_full_at_capacity, (out_valid_q && out_q.status == STATUS_FULL) |-> (out_q.occupancy == CAPACITY))
  `BHPQ_ASSERT(a_empty_clean, (out_valid_q && out_q.status == STATUS_EMPTY) |-> (out_q.occupancy == '0) && (out_q.out_key == '0) && (out_q.out_payload == '0))

endmodule

// File: tb/sv/binary_heap_priority_queue_tb.sv
`timescale 1ns / 100ps

module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_wdata_i;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  binary_heap_priority_queue DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // Shadow heap, one-based like the block
  entry_t           shadow_heap [1:HEAP_SLOTS-1];
  logic [CNT_W-1:0] shadow_count = '0;
  logic             min_first    = 1'b0;

  out_item_t results_pending [$];
  out_item_t oldest_result;
  int        fail_count  = 0;
  logic      hold_req;
  logic      steady_run;
  int        hold_left   = 0;
  bit        hold_served = 1'b0;

  // Directed items; a fixed row carries its own expected result
  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  dir_row_t directed_ops [0:19] = '{
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b1, '{STATUS_EMPTY, 16'h0000, 32'h00000000, 10'd0}},
    '{'{OP_PUSH, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{STATUS_DONE,  16'h0000, 32'h00000000, 10'd1}},
    '{'{OP_PUSH, 16'h0000, 32'h00000000}, 1'b1, '{STATUS_DONE,  16'h0000, 32'h00000000, 10'd2}},
    '{'{OP_PUSH, 16'h8000, 32'h12345678}, 1'b1, '{STATUS_DONE,  16'h0000, 32'h00000000, 10'd3}},
    '{'{OP_POP,  16'hFFFF, 32'h00000000}, 1'b1, '{STATUS_DONE,  16'hFFFF, 32'hFFFFFFFF, 10'd2}},
    '{'{OP_PUSH, 16'hFFFF, 32'hA5A5A5A5}, 1'b0, '0},
    '{'{OP_PUSH, 16'hFFFF, 32'h5A5A5A5A}, 1'b0, '0},
    '{'{OP_PUSH, 16'h0001, 32'h00000001}, 1'b0, '0},
    '{'{OP_PUSH, 16'h7FFF, 32'h80000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b0, '0},
    '{'{OP_POP,  16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{STATUS_EMPTY, 16'h0000, 32'h00000000, 10'd0}},
    '{'{OP_PUSH, 16'hAAAA, 32'h55555555}, 1'b1, '{STATUS_DONE,  16'h0000, 32'h00000000, 10'd1}},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b1, '{STATUS_DONE,  16'hAAAA, 32'h55555555, 10'd0}},
    '{'{OP_PUSH, 16'h5555, 32'hAAAAAAAA}, 1'b1, '{STATUS_DONE,  16'h0000, 32'h00000000, 10'd1}},
    '{'{OP_POP,  16'h0000, 32'h00000000}, 1'b1, '{STATUS_DONE,  16'h5555, 32'hAAAAAAAA, 10'd0}}
  };

  // Strict priority test under the current order
  function automatic bit outranks(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    return min_first ? (a < b) : (a > b);
  endfunction

  function automatic void swap_entries(int a, int b);
    entry_t tmp;
    tmp = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = tmp;
  endfunction

  // Applies one accepted item to the shadow heap and returns its result
  function automatic out_item_t apply_heap_op(in_item_t it);
    out_item_t res;
    int        pos;
    int        pick;
    res = '0;
    res.status = STATUS_DONE;
    if (it.op == OP_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        shadow_count++;
        shadow_heap[shadow_count] = '{key: it.key, payload: it.payload};
        // sift up
        pos = int'(shadow_count);
        while (pos > 1) begin
          if (!outranks(shadow_heap[pos].key, shadow_heap[pos/2].key)) break;
          swap_entries(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else if (shadow_count == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.out_key     = shadow_heap[1].key;
      res.out_payload = shadow_heap[1].payload;
      shadow_heap[1]  = shadow_heap[shadow_count];
      shadow_count--;
      // sift down, left child unless the right one is strictly better
      pos = 1;
      while (pos * 2 <= int'(shadow_count)) begin
        pick = pos * 2;
        if (pick + 1 <= int'(shadow_count) &&
            outranks(shadow_heap[pick+1].key, shadow_heap[pick].key)) begin
          pick = pick + 1;
        end
        if (!outranks(shadow_heap[pick].key, shadow_heap[pos].key)) break;
        swap_entries(pos, pick);
        pos = pick;
      end
    end
    res.occupancy = shadow_count;
    return res;
  endfunction

  // Random item; keys lean to extremes and small values so ties are common
  function automatic in_item_t random_item(int push_pct);
    in_item_t it;
    it.op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    case ($urandom_range(0, 9))
      0:       it.key = '0;
      1:       it.key = '1;
      2, 3, 4: it.key = KEY_BITS'($urandom_range(0, 7));
      default: it.key = KEY_BITS'($urandom);
    endcase
    it.payload = PAYLOAD_BITS'($urandom);
    return it;
  endfunction

  // Offer one item, wait for acceptance, queue its expected result
  task automatic send_item(input in_item_t it, input bit fixed, input out_item_t want);
    out_item_t predicted;
    if (!steady_run && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predicted = apply_heap_op(it);
    results_pending.push_back(fixed ? want : predicted);
  endtask

  task automatic run_mixed(input int n, input int push_pct);
    for (int i = 0; i < n; i++) send_item(random_item(push_pct), 1'b0, '0);
  endtask

  // Order change only once every result is back and the block has settled
  task automatic set_order(input logic mode);
    in_valid_i <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    min_first = mode;
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result sink: random stalls, one long hold-off, quiet stretch
  always @(posedge clk_i) begin
    if (hold_req && !hold_served) begin
      hold_served = 1'b1;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (steady_run) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 7);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (results_pending.size() == 0) begin
        $error("result with none pending: %p", out_item_o);
        fail_count++;
      end else begin
        oldest_result = results_pending.pop_front();
        if (out_item_o.status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, out_item_o.status);
          fail_count++;
        end
        if (out_item_o.out_key !== oldest_result.out_key) begin
          $error("out_key: expected %h, got %h", oldest_result.out_key, out_item_o.out_key);
          fail_count++;
        end
        if (out_item_o.out_payload !== oldest_result.out_payload) begin
          $error("out_payload: expected %h, got %h",
                 oldest_result.out_payload, out_item_o.out_payload);
          fail_count++;
        end
        if (out_item_o.occupancy !== oldest_result.occupancy) begin
          $error("occupancy: expected %0d, got %0d",
                 oldest_result.occupancy, out_item_o.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("binary_heap_priority_queue verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    int fill_n;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    hold_req    <= 1'b0;
    steady_run  <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // largest first: extremes, ties, empty pops
    set_order(1'b0);
    foreach (directed_ops[i]) send_item(directed_ops[i].item, directed_ops[i].fixed,
                                        directed_ops[i].want);
    run_mixed(30, 55);

    // smallest first with entries still held; sink holds off meanwhile
    set_order(1'b1);
    hold_req <= 1'b1;
    run_mixed(30, 55);

    // back to largest first, fill to capacity, overflow, then drain a while
    set_order(1'b0);
    fill_n = 0;
    while (shadow_count < CAPACITY) begin
      steady_run <= (fill_n >= 200 && fill_n < 500);
      send_item(random_item(100), 1'b0, '0);
      fill_n++;
    end
    steady_run <= 1'b0;
    run_mixed(4, 100);
    run_mixed(40, 30);

    // wait out the last results
    in_valid_i <= 1'b0;
    while (results_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("binary_heap_priority_queue verification clean");
    end else begin
      $display("binary_heap_priority_queue verification failed");
    end
    $finish;
  end

endmodule
